// ===== rtl/multi_flow_packet_pacer_unit_defines.svh =====
// Assertion macros for the packet pacer.
`ifndef MULTI_FLOW_PACKET_PACER_UNIT_DEFINES_SVH
`define MULTI_FLOW_PACKET_PACER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MFPP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFPP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/mfpp_pkg.sv =====
package mfpp_pkg;

	localparam int TIME_W        = 48;
	localparam int IV_W          = 32;
	localparam int CNT_W         = 16;
	localparam int FLOW_W        = 2;
	localparam int K_W           = TIME_W + 1;
	localparam int CFG_REGS      = 4;
	localparam int CFG_IDX_W     = 2;
	localparam int NUM_FLOWS_DEF = 4;

	localparam logic [CNT_W-1:0]  MAX_BURST = 16'd65535;
	localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

	localparam int DIV_STEPS = TIME_W;
	localparam int MUL_STEPS = IV_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	typedef struct packed {
		logic busy;
		logic done;
	} mfpp_unit_stat_t;

endpackage

// ===== rtl/mfpp_div.sv =====
module mfpp_div import mfpp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_W-1:0]    dividend,
	input  logic [IV_W-1:0]      divisor,
	output logic [TIME_W-1:0]    quotient,
	output mfpp_unit_stat_t      stat
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

	logic [TIME_W-1:0]    dvd_q;
	logic [IV_W-1:0]      dvs_q;
	logic [IV_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [IV_W:0]        trial;
	logic [IV_W:0]        trial_sub;
	logic                 take;

	assign trial     = {rem_q, dvd_q[TIME_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign take      = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= take ? trial_sub[IV_W-1:0] : trial[IV_W-1:0];
				dvd_q <= {dvd_q[TIME_W-2:0], take};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/mfpp_mul.sv =====
module mfpp_mul import mfpp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [K_W-1:0]       mcand,
	input  logic [IV_W-1:0]      mplier,
	output logic [TIME_W-1:0]    product,
	output mfpp_unit_stat_t      stat
);

	localparam logic [MUL_CNT_W-1:0] LAST_STEP = MUL_CNT_W'(MUL_STEPS - 1);

	logic [K_W-1:0]       mcand_q;
	logic [IV_W-1:0]      mplier_q;
	logic [TIME_W-1:0]    acc_q;
	logic                 ovf_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_W+1:0]    sum;

	assign sum = {1'b0, acc_q, 1'b0} + (mplier_q[IV_W-1] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mcand_q  <= mcand;
				mplier_q <= mplier;
				acc_q    <= '0;
				ovf_q    <= 1'b0;
				cnt_q    <= '0;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				acc_q    <= sum[TIME_W-1:0];
				ovf_q    <= ovf_q | (sum[TIME_W+1:TIME_W] != 2'b00);
				mplier_q <= {mplier_q[IV_W-2:0], 1'b0};
				cnt_q    <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// saturate once any partial product leaves the time range
	assign product   = ovf_q ? TIME_MAX : acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/multi_flow_packet_pacer_unit.sv =====
// channel  dir  handshake             payload
// in       in   in_valid / in_ready   elapsed_time
// out      out  out_valid / out_ready flow_index packet_count next_due_time
//                                     earliest_due_time last_flow
// cfg      in   cfg_wr_en             cfg_index cfg_data
//
// An enabled flow runs a 48-step bit-serial divider, a 32-step bit-serial
// multiplier and the control states around them. A disabled flow skips both.
// One input beat steps through all NUM_FLOWS flows in order.
// Reset clears intervals and sent counts at once; there is no clearing pass.
// An output stall holds the pacer before the next flow; in_ready is high
// only between items, while the last result may still wait in the output.
`include "multi_flow_packet_pacer_unit_defines.svh"

module multi_flow_packet_pacer_unit import mfpp_pkg::*; #(
	parameter int NUM_FLOWS = NUM_FLOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    elapsed_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FLOW_W-1:0]    flow_index,
	output logic [CNT_W-1:0]     packet_count,
	output logic [TIME_W-1:0]    next_due_time,
	output logic [TIME_W-1:0]    earliest_due_time,
	output logic                 last_flow,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IV_W-1:0]      cfg_data
);

	localparam int SENT_IDX_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam logic [FLOW_W-1:0] LAST_FLOW = FLOW_W'(NUM_FLOWS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_DIFF,
		S_SAT,
		S_ADV,
		S_MUL,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [IV_W-1:0]     interval_q [CFG_REGS];
	logic [TIME_W-1:0]   packets_sent_q [NUM_FLOWS];
	logic [FLOW_W-1:0]   flow_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [TIME_W-1:0]   due_q;
	logic [TIME_W:0]     diff_q;
	logic [TIME_W-1:0]   sent_cur_q;
	logic [CNT_W-1:0]    count_q;
	logic [TIME_W-1:0]   next_q;
	logic [TIME_W-1:0]   earliest_q;

	logic                out_valid_q;
	logic [FLOW_W-1:0]   flow_index_q;
	logic [CNT_W-1:0]    packet_count_q;
	logic [TIME_W-1:0]   next_due_q;
	logic [TIME_W-1:0]   earliest_out_q;
	logic                last_flow_q;

	logic [IV_W-1:0]       iv_cur;
	logic [TIME_W-1:0]     sent_rd;
	logic [TIME_W-1:0]     sent_new;
	logic [K_W-1:0]        mul_mcand;
	logic                  div_start;
	logic                  mul_start;
	logic [TIME_W-1:0]     quotient;
	logic [TIME_W-1:0]     product;
	logic                  is_last;
	logic                  emit;
	mfpp_unit_stat_t       div_stat;
	mfpp_unit_stat_t       mul_stat;

	assign iv_cur    = interval_q[flow_q];
	assign sent_rd   = packets_sent_q[flow_q[SENT_IDX_W-1:0]];
	assign sent_new  = sent_cur_q + TIME_W'(count_q);
	assign mul_mcand = {1'b0, sent_new} + K_W'(1);
	assign div_start = (state_q == S_LOAD) && (iv_cur != '0);
	assign mul_start = (state_q == S_ADV);
	assign is_last   = (flow_q == LAST_FLOW);
	assign in_ready  = (state_q == S_IDLE);
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	mfpp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed_q),
		.divisor  (iv_cur),
		.quotient (quotient),
		.stat     (div_stat)
	);

	mfpp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (iv_cur),
		.product (product),
		.stat    (mul_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) begin
				interval_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			interval_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			flow_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FLOWS; i++) begin
				packets_sent_q[i] <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						elapsed_q  <= elapsed_time;
						earliest_q <= TIME_MAX;
						flow_q     <= '0;
						state_q    <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (iv_cur == '0) begin
						count_q <= '0;
						next_q  <= TIME_MAX;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						due_q   <= quotient;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					diff_q     <= {1'b0, due_q} - {1'b0, sent_rd};
					sent_cur_q <= sent_rd;
					state_q    <= S_SAT;
				end
				S_SAT: begin
					if (diff_q[TIME_W]) begin
						count_q <= '0;
					end else if (diff_q[TIME_W-1:0] > TIME_W'(MAX_BURST)) begin
						count_q <= MAX_BURST;
					end else begin
						count_q <= diff_q[CNT_W-1:0];
					end
					state_q <= S_ADV;
				end
				S_ADV: begin
					packets_sent_q[flow_q[SENT_IDX_W-1:0]] <= sent_new;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_stat.done) begin
						next_q <= product;
						if (product < earliest_q) begin
							earliest_q <= product;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						flow_index_q   <= flow_q;
						packet_count_q <= count_q;
						next_due_q     <= next_q;
						earliest_out_q <= is_last ? earliest_q : '0;
						last_flow_q    <= is_last;
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							flow_q  <= flow_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign flow_index        = flow_index_q;
	assign packet_count      = packet_count_q;
	assign next_due_time     = next_due_q;
	assign earliest_due_time = earliest_out_q;
	assign last_flow         = last_flow_q;

	`MFPP_ASSERT(a_idle_units, clk, arst_n, in_ready |-> (!div_stat.busy && !mul_stat.busy), "serial unit busy while taking a beat")
	`MFPP_ASSERT(a_div_running, clk, arst_n, (state_q == S_DIV) |-> (div_stat.busy || div_stat.done), "waiting on an idle divider")
	`MFPP_ASSERT(a_mul_running, clk, arst_n, (state_q == S_MUL) |-> (mul_stat.busy || mul_stat.done), "waiting on an idle multiplier")
	`MFPP_ASSERT(a_last_index, clk, arst_n, (out_valid_q && last_flow_q) |-> (flow_index_q == LAST_FLOW), "last beat on wrong flow")
	`MFPP_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!out_valid && in_ready), "outputs active in reset")

endmodule
